// ----- hdl/cpu8_execute_unit_top_defines.svh -----
// ---------------------------------------------------------------------------
// cpu8_execute_unit_top_defines.svh
// Assertion helpers for the execute unit. All checks sample on clk and are
// off while rst is high.
// ---------------------------------------------------------------------------
`ifndef CPU8_EXECUTE_UNIT_TOP_DEFINES_SVH
`define CPU8_EXECUTE_UNIT_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CPU8_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPU8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cpu8eu_pkg.sv -----
// ---------------------------------------------------------------------------
// cpu8eu_pkg
// Shared types and constants of the 8-bit execute unit: channel payloads,
// register file, ALU operations and decoded control word.
// ---------------------------------------------------------------------------
`default_nettype none

package cpu8eu_pkg;

  // Status byte NV1BDIZC: bit positions
  localparam int unsigned P_C = 0;
  localparam int unsigned P_Z = 1;
  localparam int unsigned P_I = 2;
  localparam int unsigned P_D = 3;
  localparam int unsigned P_B = 4;
  localparam int unsigned P_U = 5;
  localparam int unsigned P_V = 6;
  localparam int unsigned P_N = 7;

  // Status byte masks
  localparam logic [7:0] FLG_C = 8'h01;
  localparam logic [7:0] FLG_Z = 8'h02;
  localparam logic [7:0] FLG_I = 8'h04;
  localparam logic [7:0] FLG_D = 8'h08;
  localparam logic [7:0] FLG_B = 8'h10;
  localparam logic [7:0] FLG_U = 8'h20;
  localparam logic [7:0] FLG_V = 8'h40;
  localparam logic [7:0] FLG_N = 8'h80;

  typedef enum logic [3:0] {
    ALU_PASS,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_ADC,
    ALU_SBC,
    ALU_CMP,
    ALU_INC,
    ALU_DEC,
    ALU_ASL,
    ALU_ROL,
    ALU_LSR,
    ALU_ROR,
    ALU_BIT
  } alu_op_t;

  // Left ALU operand source
  typedef enum logic [2:0] {
    SRC_OPND,
    SRC_A,
    SRC_X,
    SRC_Y,
    SRC_S,
    SRC_P
  } src_t;

  // Register written by the ALU result
  typedef enum logic [2:0] {
    DST_NONE,
    DST_A,
    DST_X,
    DST_Y,
    DST_S
  } dst_t;

  typedef struct packed {
    alu_op_t    alu_op;
    src_t       lhs_sel;
    dst_t       dst;
    logic       upd_nz;
    logic       upd_c;
    logic       upd_v;
    logic       mem_wr;
    logic       push;
    logic       pull;
    logic       load_p;
    logic       branch;
    logic       bad;
    logic [7:0] flg_clr;
    logic [7:0] flg_set;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } arch_t;

  localparam arch_t ARCH_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, s: 8'hFD, p: 8'h24};

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand_value;
    logic [15:0] effective_address;
  } instr_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  xreg_out;
    logic [7:0]  yreg_out;
    logic [7:0]  flags_out;
    logic [7:0]  stack_ptr_out;
    logic        mem_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        branch_taken;
    logic        bad_opcode;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/cpu8eu_decode.sv -----
// ---------------------------------------------------------------------------
// cpu8eu_decode
// Opcode decoder. Uses the aaa-bbb-cc field layout of the opcode byte for
// the addressed groups and a direct match for single-byte instructions.
// ---------------------------------------------------------------------------
`default_nettype none

module cpu8eu_decode import cpu8eu_pkg::*; (
  input  logic [7:0] opcode,
  output ctrl_t      ctl
);

  // Single-byte instructions
  localparam logic [7:0] OPC_PHP = 8'h08;
  localparam logic [7:0] OPC_CLC = 8'h18;
  localparam logic [7:0] OPC_PLP = 8'h28;
  localparam logic [7:0] OPC_SEC = 8'h38;
  localparam logic [7:0] OPC_PHA = 8'h48;
  localparam logic [7:0] OPC_CLI = 8'h58;
  localparam logic [7:0] OPC_PLA = 8'h68;
  localparam logic [7:0] OPC_SEI = 8'h78;
  localparam logic [7:0] OPC_DEY = 8'h88;
  localparam logic [7:0] OPC_TXA = 8'h8A;
  localparam logic [7:0] OPC_TYA = 8'h98;
  localparam logic [7:0] OPC_TXS = 8'h9A;
  localparam logic [7:0] OPC_TAY = 8'hA8;
  localparam logic [7:0] OPC_TAX = 8'hAA;
  localparam logic [7:0] OPC_CLV = 8'hB8;
  localparam logic [7:0] OPC_TSX = 8'hBA;
  localparam logic [7:0] OPC_INY = 8'hC8;
  localparam logic [7:0] OPC_DEX = 8'hCA;
  localparam logic [7:0] OPC_CLD = 8'hD8;
  localparam logic [7:0] OPC_INX = 8'hE8;
  localparam logic [7:0] OPC_NOP = 8'hEA;
  localparam logic [7:0] OPC_SED = 8'hF8;

  // cc groups
  localparam logic [1:0] CC_G0 = 2'b00;
  localparam logic [1:0] CC_G1 = 2'b01;
  localparam logic [1:0] CC_G2 = 2'b10;

  // bbb address modes
  localparam logic [2:0] BBB_IMM    = 3'b000;
  localparam logic [2:0] BBB_ZP     = 3'b001;
  localparam logic [2:0] BBB_ACC    = 3'b010;
  localparam logic [2:0] BBB_G1_IMM = 3'b010;
  localparam logic [2:0] BBB_ABS    = 3'b011;
  localparam logic [2:0] BBB_BRANCH = 3'b100;
  localparam logic [2:0] BBB_ZPX    = 3'b101;
  localparam logic [2:0] BBB_ABSX   = 3'b111;

  // aaa operations, group one
  localparam logic [2:0] G1_ORA = 3'd0;
  localparam logic [2:0] G1_AND = 3'd1;
  localparam logic [2:0] G1_EOR = 3'd2;
  localparam logic [2:0] G1_ADC = 3'd3;
  localparam logic [2:0] G1_STA = 3'd4;
  localparam logic [2:0] G1_LDA = 3'd5;
  localparam logic [2:0] G1_CMP = 3'd6;
  localparam logic [2:0] G1_SBC = 3'd7;

  // aaa operations, group two
  localparam logic [2:0] G2_ASL = 3'd0;
  localparam logic [2:0] G2_ROL = 3'd1;
  localparam logic [2:0] G2_LSR = 3'd2;
  localparam logic [2:0] G2_ROR = 3'd3;
  localparam logic [2:0] G2_STX = 3'd4;
  localparam logic [2:0] G2_LDX = 3'd5;
  localparam logic [2:0] G2_DEC = 3'd6;
  localparam logic [2:0] G2_INC = 3'd7;

  // aaa operations, group zero
  localparam logic [2:0] G0_BIT = 3'd1;
  localparam logic [2:0] G0_STY = 3'd4;
  localparam logic [2:0] G0_LDY = 3'd5;
  localparam logic [2:0] G0_CPY = 3'd6;
  localparam logic [2:0] G0_CPX = 3'd7;

  logic [2:0] aaa;
  logic [2:0] bbb;
  logic [1:0] cc;
  logic       mem_mode;

  assign aaa      = opcode[7:5];
  assign bbb      = opcode[4:2];
  assign cc       = opcode[1:0];
  // zp, abs, zp-indexed and abs-indexed all have bbb[0] set in group two
  assign mem_mode = bbb[0];

  always_comb begin
    ctl         = '0;
    ctl.alu_op  = ALU_PASS;
    ctl.lhs_sel = SRC_OPND;
    ctl.dst     = DST_NONE;
    case (opcode)
      OPC_PHP: begin
        ctl.lhs_sel = SRC_P;
        ctl.mem_wr  = 1'b1;
        ctl.push    = 1'b1;
      end
      OPC_PHA: begin
        ctl.lhs_sel = SRC_A;
        ctl.mem_wr  = 1'b1;
        ctl.push    = 1'b1;
      end
      OPC_PLP: begin
        ctl.load_p = 1'b1;
        ctl.pull   = 1'b1;
      end
      OPC_PLA: begin
        ctl.dst    = DST_A;
        ctl.upd_nz = 1'b1;
        ctl.pull   = 1'b1;
      end
      OPC_DEY: begin
        ctl.alu_op  = ALU_DEC;
        ctl.lhs_sel = SRC_Y;
        ctl.dst     = DST_Y;
        ctl.upd_nz  = 1'b1;
      end
      OPC_INY: begin
        ctl.alu_op  = ALU_INC;
        ctl.lhs_sel = SRC_Y;
        ctl.dst     = DST_Y;
        ctl.upd_nz  = 1'b1;
      end
      OPC_DEX: begin
        ctl.alu_op  = ALU_DEC;
        ctl.lhs_sel = SRC_X;
        ctl.dst     = DST_X;
        ctl.upd_nz  = 1'b1;
      end
      OPC_INX: begin
        ctl.alu_op  = ALU_INC;
        ctl.lhs_sel = SRC_X;
        ctl.dst     = DST_X;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TAY: begin
        ctl.lhs_sel = SRC_A;
        ctl.dst     = DST_Y;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TAX: begin
        ctl.lhs_sel = SRC_A;
        ctl.dst     = DST_X;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TYA: begin
        ctl.lhs_sel = SRC_Y;
        ctl.dst     = DST_A;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TXA: begin
        ctl.lhs_sel = SRC_X;
        ctl.dst     = DST_A;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TSX: begin
        ctl.lhs_sel = SRC_S;
        ctl.dst     = DST_X;
        ctl.upd_nz  = 1'b1;
      end
      OPC_TXS: begin
        // no flag update on a move into S
        ctl.lhs_sel = SRC_X;
        ctl.dst     = DST_S;
      end
      OPC_CLC: ctl.flg_clr = FLG_C;
      OPC_SEC: ctl.flg_set = FLG_C;
      OPC_CLI: ctl.flg_clr = FLG_I;
      OPC_SEI: ctl.flg_set = FLG_I;
      OPC_CLV: ctl.flg_clr = FLG_V;
      OPC_CLD: ctl.flg_clr = FLG_D;
      OPC_SED: ctl.flg_set = FLG_D;
      OPC_NOP: ctl.bad = 1'b0;
      default: begin
        if (cc == CC_G1) begin
          ctl.lhs_sel = SRC_A;
          case (aaa)
            G1_ORA: begin
              ctl.alu_op = ALU_OR;
              ctl.dst    = DST_A;
              ctl.upd_nz = 1'b1;
            end
            G1_AND: begin
              ctl.alu_op = ALU_AND;
              ctl.dst    = DST_A;
              ctl.upd_nz = 1'b1;
            end
            G1_EOR: begin
              ctl.alu_op = ALU_XOR;
              ctl.dst    = DST_A;
              ctl.upd_nz = 1'b1;
            end
            G1_ADC: begin
              ctl.alu_op = ALU_ADC;
              ctl.dst    = DST_A;
              ctl.upd_nz = 1'b1;
              ctl.upd_c  = 1'b1;
              ctl.upd_v  = 1'b1;
            end
            G1_SBC: begin
              ctl.alu_op = ALU_SBC;
              ctl.dst    = DST_A;
              ctl.upd_nz = 1'b1;
              ctl.upd_c  = 1'b1;
              ctl.upd_v  = 1'b1;
            end
            G1_STA: begin
              // store immediate does not exist
              if (bbb == BBB_G1_IMM) begin
                ctl.bad = 1'b1;
              end else begin
                ctl.mem_wr = 1'b1;
              end
            end
            G1_LDA: begin
              ctl.lhs_sel = SRC_OPND;
              ctl.dst     = DST_A;
              ctl.upd_nz  = 1'b1;
            end
            G1_CMP: begin
              ctl.alu_op = ALU_CMP;
              ctl.upd_nz = 1'b1;
              ctl.upd_c  = 1'b1;
            end
            default: ctl.bad = 1'b1;
          endcase
        end else if (cc == CC_G2) begin
          case (aaa)
            G2_ASL, G2_ROL, G2_LSR, G2_ROR: begin
              case (aaa)
                G2_ASL:  ctl.alu_op = ALU_ASL;
                G2_ROL:  ctl.alu_op = ALU_ROL;
                G2_LSR:  ctl.alu_op = ALU_LSR;
                default: ctl.alu_op = ALU_ROR;
              endcase
              ctl.upd_nz = 1'b1;
              ctl.upd_c  = 1'b1;
              if (bbb == BBB_ACC) begin
                ctl.lhs_sel = SRC_A;
                ctl.dst     = DST_A;
              end else if (mem_mode) begin
                ctl.mem_wr = 1'b1;
              end else begin
                ctl = '0;
                ctl.bad = 1'b1;
              end
            end
            G2_STX: begin
              if (bbb == BBB_ZP || bbb == BBB_ABS || bbb == BBB_ZPX) begin
                ctl.lhs_sel = SRC_X;
                ctl.mem_wr  = 1'b1;
              end else begin
                ctl.bad = 1'b1;
              end
            end
            G2_LDX: begin
              if (bbb == BBB_IMM || mem_mode) begin
                ctl.dst    = DST_X;
                ctl.upd_nz = 1'b1;
              end else begin
                ctl.bad = 1'b1;
              end
            end
            G2_DEC, G2_INC: begin
              if (mem_mode) begin
                ctl.alu_op = (aaa == G2_INC) ? ALU_INC : ALU_DEC;
                ctl.upd_nz = 1'b1;
                ctl.mem_wr = 1'b1;
              end else begin
                ctl.bad = 1'b1;
              end
            end
            default: ctl.bad = 1'b1;
          endcase
        end else if (cc == CC_G0) begin
          if (bbb == BBB_BRANCH) begin
            ctl.branch = 1'b1;
          end else begin
            case (aaa)
              G0_BIT: begin
                if (bbb == BBB_ZP || bbb == BBB_ABS) begin
                  ctl.alu_op  = ALU_BIT;
                  ctl.lhs_sel = SRC_A;
                  ctl.upd_nz  = 1'b1;
                  ctl.upd_v   = 1'b1;
                end else begin
                  ctl.bad = 1'b1;
                end
              end
              G0_STY: begin
                if (bbb == BBB_ZP || bbb == BBB_ABS || bbb == BBB_ZPX) begin
                  ctl.lhs_sel = SRC_Y;
                  ctl.mem_wr  = 1'b1;
                end else begin
                  ctl.bad = 1'b1;
                end
              end
              G0_LDY: begin
                if (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS ||
                    bbb == BBB_ZPX || bbb == BBB_ABSX) begin
                  ctl.dst    = DST_Y;
                  ctl.upd_nz = 1'b1;
                end else begin
                  ctl.bad = 1'b1;
                end
              end
              G0_CPY, G0_CPX: begin
                if (bbb == BBB_IMM || bbb == BBB_ZP || bbb == BBB_ABS) begin
                  ctl.alu_op  = ALU_CMP;
                  ctl.lhs_sel = (aaa == G0_CPX) ? SRC_X : SRC_Y;
                  ctl.upd_nz  = 1'b1;
                  ctl.upd_c   = 1'b1;
                end else begin
                  ctl.bad = 1'b1;
                end
              end
              default: ctl.bad = 1'b1;
            endcase
          end
        end else begin
          ctl.bad = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/cpu8eu_alu.sv -----
// ---------------------------------------------------------------------------
// cpu8eu_alu
// 8-bit ALU: logic ops, add with carry, subtract and compare on one shared
// adder, increment, decrement, shifts and rotates, bit test.
// ---------------------------------------------------------------------------
`default_nettype none

module cpu8eu_alu import cpu8eu_pkg::*; (
  input  alu_op_t    op,
  input  logic [7:0] lhs,
  input  logic [7:0] rhs,
  input  logic       cin,
  output logic [7:0] res,
  output logic       c_out,
  output logic       v_out,
  output logic       n_out,
  output logic       z_out
);

  logic [7:0] add_b;
  logic       add_ci;
  logic [8:0] sum;
  logic [7:0] ovf;

  always_comb begin
    // SBC and CMP add the complement; CMP forces the carry in
    add_b  = (op == ALU_SBC || op == ALU_CMP) ? ~rhs : rhs;
    add_ci = (op == ALU_CMP) ? 1'b1 : cin;
    sum    = {1'b0, lhs} + {1'b0, add_b} + {8'd0, add_ci};
    ovf    = ~(lhs ^ add_b) & (lhs ^ sum[7:0]);

    res   = lhs;
    c_out = cin;
    v_out = 1'b0;
    case (op)
      ALU_PASS: res = lhs;
      ALU_AND:  res = lhs & rhs;
      ALU_OR:   res = lhs | rhs;
      ALU_XOR:  res = lhs ^ rhs;
      ALU_ADC, ALU_SBC: begin
        res   = sum[7:0];
        c_out = sum[8];
        v_out = ovf[7];
      end
      ALU_CMP: begin
        res   = sum[7:0];
        c_out = sum[8];
      end
      ALU_INC:  res = lhs + 8'd1;
      ALU_DEC:  res = lhs - 8'd1;
      ALU_ASL: begin
        res   = {lhs[6:0], 1'b0};
        c_out = lhs[7];
      end
      ALU_ROL: begin
        res   = {lhs[6:0], cin};
        c_out = lhs[7];
      end
      ALU_LSR: begin
        res   = {1'b0, lhs[7:1]};
        c_out = lhs[0];
      end
      ALU_ROR: begin
        res   = {cin, lhs[7:1]};
        c_out = lhs[0];
      end
      ALU_BIT: begin
        res   = lhs & rhs;
        v_out = rhs[6];
      end
      default: res = lhs;
    endcase

    n_out = (op == ALU_BIT) ? rhs[7] : res[7];
    z_out = (res == 8'd0);
  end

endmodule

`default_nettype wire

// ----- hdl/cpu8_execute_unit_top.sv -----
// ---------------------------------------------------------------------------
// cpu8_execute_unit_top
// Execute stage of an 8-bit core: holds A, X, Y, S and P, applies one
// decoded instruction per transfer and reports the register file, one
// optional memory write, the branch decision and an unknown-opcode flag.
//
//   Channel  Handshake                 Payload   Side
//   instr    instr_valid / instr_stall  instr_t   input
//   rslt     rslt_valid / rslt_stall    result_t  output
//
// One instruction per cycle sustained while rslt_stall is low; a result passes
// through the input register, then the result register.
// The A/X/Y/S/P update is a combinational loop through decode and the ALU.
// Reset: A=X=Y=0, S=0xFD, P=0x24, both stages empty.
// A stalled result holds; instr_stall rises only when both stages are full and rslt_stall is high.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cpu8_execute_unit_top_defines.svh"

module cpu8_execute_unit_top import cpu8eu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_stall,
  input  instr_t  instr,
  output logic    rslt_valid,
  input  logic    rslt_stall,
  output result_t rslt
);

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] PLP_KEEP   = 8'hCF;

  // branch flag select, opcode bits 7:6
  localparam logic [1:0] BR_N = 2'd0;
  localparam logic [1:0] BR_V = 2'd1;
  localparam logic [1:0] BR_C = 2'd2;

  logic    op_valid;
  instr_t  op_item;
  logic    res_valid;
  result_t res_item;
  arch_t   arch;

  arch_t   arch_next;
  result_t res_next;
  ctrl_t   ctl;
  logic    instr_xfer;
  logic    res_load;
  logic    advance;

  logic [7:0] lhs;
  logic [7:0] alu_res;
  logic       alu_c;
  logic       alu_v;
  logic       alu_n;
  logic       alu_z;
  logic [7:0] p_next;
  logic       br_flag;

  assign res_load    = !res_valid || !rslt_stall;
  assign advance     = op_valid && res_load;
  assign instr_stall = op_valid && !res_load;
  assign instr_xfer  = instr_valid && !instr_stall;

  cpu8eu_decode u_decode (
    .opcode (op_item.opcode),
    .ctl    (ctl)
  );

  always_comb begin
    case (ctl.lhs_sel)
      SRC_OPND: lhs = op_item.operand_value;
      SRC_A:    lhs = arch.a;
      SRC_X:    lhs = arch.x;
      SRC_Y:    lhs = arch.y;
      SRC_S:    lhs = arch.s;
      SRC_P:    lhs = arch.p | FLG_B | FLG_U;
      default:  lhs = op_item.operand_value;
    endcase
  end

  cpu8eu_alu u_alu (
    .op    (ctl.alu_op),
    .lhs   (lhs),
    .rhs   (op_item.operand_value),
    .cin   (arch.p[P_C]),
    .res   (alu_res),
    .c_out (alu_c),
    .v_out (alu_v),
    .n_out (alu_n),
    .z_out (alu_z)
  );

  always_comb begin
    p_next = arch.p;
    if (ctl.upd_nz) begin
      p_next[P_N] = alu_n;
      p_next[P_Z] = alu_z;
    end
    if (ctl.upd_c) begin
      p_next[P_C] = alu_c;
    end
    if (ctl.upd_v) begin
      p_next[P_V] = alu_v;
    end
    p_next = (p_next & ~ctl.flg_clr) | ctl.flg_set;
    if (ctl.load_p) begin
      p_next = (op_item.operand_value & PLP_KEEP) | FLG_U;
    end

    case (op_item.opcode[7:6])
      BR_N:    br_flag = arch.p[P_N];
      BR_V:    br_flag = arch.p[P_V];
      BR_C:    br_flag = arch.p[P_C];
      default: br_flag = arch.p[P_Z];
    endcase

    arch_next   = arch;
    arch_next.p = p_next;
    case (ctl.dst)
      DST_A:   arch_next.a = alu_res;
      DST_X:   arch_next.x = alu_res;
      DST_Y:   arch_next.y = alu_res;
      DST_S:   arch_next.s = alu_res;
      default: arch_next.a = arch.a;
    endcase
    if (ctl.push) begin
      arch_next.s = arch.s - 8'd1;
    end else if (ctl.pull) begin
      arch_next.s = arch.s + 8'd1;
    end

    res_next.acc_out       = arch_next.a;
    res_next.xreg_out      = arch_next.x;
    res_next.yreg_out      = arch_next.y;
    res_next.flags_out     = arch_next.p;
    res_next.stack_ptr_out = arch_next.s;
    res_next.mem_write     = ctl.mem_wr;
    res_next.write_address = !ctl.mem_wr ? 16'd0 :
                             ctl.push ? {STACK_PAGE, arch.s} : op_item.effective_address;
    res_next.write_data    = ctl.mem_wr ? alu_res : 8'd0;
    res_next.branch_taken  = ctl.branch && (br_flag == op_item.opcode[5]);
    res_next.bad_opcode    = ctl.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (instr_xfer) begin
      op_valid <= 1'b1;
    end else if (advance) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (instr_xfer) begin
      op_item <= instr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= ARCH_RESET;
    end else if (advance) begin
      arch <= arch_next;
    end
  end

  assign rslt_valid = res_valid;
  assign rslt       = res_item;

  `CPU8_ASSERT_SAME(a_bad_no_side_effect, rslt_valid && rslt.bad_opcode, !rslt.mem_write && !rslt.branch_taken, "unknown opcode produced a write or branch")
  `CPU8_ASSERT_SAME(a_status_fixed_bits, 1'b1, arch.p[P_U] && !arch.p[P_B], "status bit 5 clear or bit 4 set")
  `CPU8_ASSERT_NEXT(a_push_dec_sp, advance && ctl.push, arch.s == $past(arch.s) - 8'd1, "push did not decrement the stack pointer")
  `CPU8_ASSERT_NEXT(a_bad_keeps_state, advance && ctl.bad, $stable(arch), "unknown opcode changed the register file")
  `CPU8_ASSERT_NEXT(a_idle_keeps_state, !advance, $stable(arch), "register file changed without a transfer")

endmodule

`default_nettype wire
